// File: hw/rtl/scmp_pkg.sv
// shared types and constants for the flat-sky map pixelization pipeline
// used by scmp_axis and sky_coord_to_map_pixel; no dependencies
`default_nettype none

package scmp_pkg;

   // largest map side that the wrap logic handles
   localparam int MAX_SIDE = 4096;
   localparam int SIDE_W = 13;

   // coordinate magnitude carries 44 fraction bits
   localparam int MAG_W = 52;
   localparam int CELL_W = 24;
   localparam int FRAC_W = 60;

   // cell wrap works through the cell number a few bits per stage
   localparam int GROUP_W = 6;
   localparam int GROUPS = CELL_W / GROUP_W;

   // stages inside one axis lane and in the whole block
   localparam int AXIS_STAGES = 7;
   localparam int FRONT_STAGES = 4;
   localparam int PIPE_DEPTH = FRONT_STAGES + AXIS_STAGES + 1;

   localparam logic [FRAC_W:0] HALF_FRAC = (FRAC_W + 1)'(64'h0800_0000_0000_0000);
   localparam logic [FRAC_W-1:0] HALF_FRAC_N = FRAC_W'(64'h0800_0000_0000_0000);

   localparam logic signed [33:0] OFFSET_MAX = 34'sd2147483647;
   localparam logic signed [33:0] OFFSET_MIN = -34'sd2147483648;

   localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SIDE);

   typedef enum logic [2:0] {
      CSR_RA_SCALED_MIN,
      CSR_DEC_MIN,
      CSR_RA_CENTRE,
      CSR_PIXEL_SIZE,
      CSR_INVERSE_PIXEL_SIZE,
      CSR_MAP_WIDTH,
      CSR_MAP_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic [31:0] inverse_pixel_size;
      logic [30:0] pixel_size;
      logic [SIDE_W-1:0] side;
   } axis_cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/sky_coord_to_map_pixel.sv
// top level of the flat-sky map pixelization block: config registers,
// front-end arithmetic, two axis lanes and the pixel index; uses scmp_pkg, scmp_axis
//
// usage:
//   input channel: a sample is taken at each rising edge with start high;
//   busy is always low, so a new sample may enter in every cycle.
//   result channel: rsp_valid is high for one cycle with the pixel index,
//   both offsets and the last flag of one sample; the receiver cannot stall,
//   so nothing ever backs up.
//   csr channel: csr_ready is always high; a write lands at an edge with
//   csr_valid high, csr_index selecting the register. write registers only
//   while no sample is in flight.
//   pipeline: throughput one sample per cycle through the 12 register
//   stages: 4 front stages (differences, cos multiply, offset
//   subtract, magnitude), 7 stages per axis lane (split multiplies and
//   the cell wrap, 6 bits per stage) and the index multiply.
//   reset: clears all valid bits and loads register defaults; no clearing pass.
`default_nettype none

module sky_coord_to_map_pixel (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_right_ascension,
   input  wire logic signed [31:0] req_declination,
   input  wire logic signed [17:0] req_cos_declination,
   input  wire logic               req_last_in,
   output logic                    rsp_valid,
   output logic [23:0]             rsp_pixel_index,
   output logic signed [31:0]      rsp_offset_x,
   output logic signed [31:0]      rsp_offset_y,
   output logic                    rsp_last_out,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam int LINE_LEN = scmp_pkg::FRONT_STAGES + scmp_pkg::AXIS_STAGES;

   logic signed [31:0] ra_scaled_min_ff;
   logic signed [31:0] dec_min_ff;
   logic signed [31:0] ra_centre_ff;
   logic [30:0] pixel_size_ff;
   logic [31:0] inverse_pixel_size_ff;
   logic [12:0] map_width_ff;
   logic [12:0] map_height_ff;

   logic [scmp_pkg::SIDE_W-1:0] side_w, side_h;
   scmp_pkg::axis_cfg_type cfg_x, cfg_y;

   logic accept;
   logic [0:LINE_LEN-1] valid_ff;
   logic [0:LINE_LEN-1] last_ff;

   logic signed [32:0] dra_ff, dra_in;
   logic signed [32:0] ddec1_ff, ddec1_in;
   logic signed [17:0] cos1_ff;
   logic signed [50:0] prodx_ff, prodx_in;
   logic signed [32:0] ddec2_ff;
   logic signed [51:0] ux_ff, ux_in;
   logic signed [32:0] ddec3_ff;
   logic signed [51:0] uy;
   logic [scmp_pkg::MAG_W-1:0] magx_ff, magx_in, magy_ff, magy_in;
   logic negx_ff, negy_ff;

   logic [scmp_pkg::SIDE_W-1:0] cellx, celly;
   logic signed [31:0] offx, offy;

   logic rsp_valid_ff, last_out_ff;
   logic [23:0] pixel_index_ff, pixel_index_in;
   logic [25:0] index_sum;
   logic signed [31:0] offset_x_ff, offset_y_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;
   assign accept = start && !busy;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ra_scaled_min_ff <= '0;
         dec_min_ff <= '0;
         ra_centre_ff <= '0;
         pixel_size_ff <= 31'd78090;
         inverse_pixel_size_ff <= 32'd225296187;
         map_width_ff <= 13'd1024;
         map_height_ff <= 13'd1024;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            scmp_pkg::CSR_RA_SCALED_MIN: begin
               ra_scaled_min_ff <= $signed(csr_wdata);
            end
            scmp_pkg::CSR_DEC_MIN: begin
               dec_min_ff <= $signed(csr_wdata);
            end
            scmp_pkg::CSR_RA_CENTRE: begin
               ra_centre_ff <= $signed(csr_wdata);
            end
            scmp_pkg::CSR_PIXEL_SIZE: begin
               pixel_size_ff <= csr_wdata[30:0];
            end
            scmp_pkg::CSR_INVERSE_PIXEL_SIZE: begin
               inverse_pixel_size_ff <= csr_wdata;
            end
            scmp_pkg::CSR_MAP_WIDTH: begin
               map_width_ff <= csr_wdata[12:0];
            end
            scmp_pkg::CSR_MAP_HEIGHT: begin
               map_height_ff <= csr_wdata[12:0];
            end
            default: begin
            end
         endcase
      end
   end

   // zero side acts as one, oversize side as the limit
   always_comb begin
      if (map_width_ff == '0) begin
         side_w = scmp_pkg::SIDE_W'(1);
      end else if (map_width_ff > scmp_pkg::SIDE_LIMIT) begin
         side_w = scmp_pkg::SIDE_LIMIT;
      end else begin
         side_w = map_width_ff;
      end
      if (map_height_ff == '0) begin
         side_h = scmp_pkg::SIDE_W'(1);
      end else if (map_height_ff > scmp_pkg::SIDE_LIMIT) begin
         side_h = scmp_pkg::SIDE_LIMIT;
      end else begin
         side_h = map_height_ff;
      end
      cfg_x = '{inverse_pixel_size: inverse_pixel_size_ff,
                pixel_size: pixel_size_ff, side: side_w};
      cfg_y = '{inverse_pixel_size: inverse_pixel_size_ff,
                pixel_size: pixel_size_ff, side: side_h};
   end

   // front end
   always_comb begin
      dra_in = 33'(req_right_ascension) - 33'(ra_centre_ff);
      ddec1_in = 33'(req_declination) - 33'(dec_min_ff);
      prodx_in = 51'(dra_ff) * 51'(cos1_ff);
      ux_in = 52'(prodx_ff) - 52'($signed({ra_scaled_min_ff, 16'b0}));
      uy = 52'($signed({ddec3_ff, 16'b0}));
      magx_in = ux_ff[51] ? scmp_pkg::MAG_W'(-ux_ff) : scmp_pkg::MAG_W'(ux_ff);
      magy_in = uy[51] ? scmp_pkg::MAG_W'(-uy) : scmp_pkg::MAG_W'(uy);
   end

   always_ff @(posedge clock) begin
      dra_ff <= dra_in;
      ddec1_ff <= ddec1_in;
      cos1_ff <= req_cos_declination;
      prodx_ff <= prodx_in;
      ddec2_ff <= ddec1_ff;
      ux_ff <= ux_in;
      ddec3_ff <= ddec2_ff;
      magx_ff <= magx_in;
      negx_ff <= ux_ff[51];
      magy_ff <= magy_in;
      negy_ff <= uy[51];
   end

   scmp_axis u_axis_x (
      .clock    (clock),
      .mag      (magx_ff),
      .neg      (negx_ff),
      .cfg      (cfg_x),
      .cell_num (cellx),
      .offset   (offx)
   );

   scmp_axis u_axis_y (
      .clock    (clock),
      .mag      (magy_ff),
      .neg      (negy_ff),
      .cfg      (cfg_y),
      .cell_num (celly),
      .offset   (offy)
   );

   // valid and last travel alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         last_ff <= '0;
         rsp_valid_ff <= 1'b0;
         last_out_ff <= 1'b0;
      end else begin
         valid_ff[0] <= accept;
         last_ff[0] <= accept && req_last_in;
         for (int s = 1; s < LINE_LEN; s++) begin
            valid_ff[s] <= valid_ff[s-1];
            last_ff[s] <= last_ff[s-1];
         end
         rsp_valid_ff <= valid_ff[LINE_LEN-1];
         last_out_ff <= last_ff[LINE_LEN-1];
      end
   end

   always_comb begin
      index_sum = 26'(cellx) + 26'(side_w) * 26'(celly);
      pixel_index_in = index_sum[23:0];
   end

   always_ff @(posedge clock) begin
      pixel_index_ff <= pixel_index_in;
      offset_x_ff <= offx;
      offset_y_ff <= offy;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_index = pixel_index_ff;
   assign rsp_offset_x = offset_x_ff;
   assign rsp_offset_y = offset_y_ff;
   assign rsp_last_out = last_out_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(scmp_pkg::PIPE_DEPTH) rsp_valid)
      else $error("accepted transaction did not complete on time");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, scmp_pkg::PIPE_DEPTH))
      else $error("result without an accepted transaction");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_out |-> rsp_valid)
      else $error("last flag outside a result");

   a_last_kept: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_in) |-> ##(scmp_pkg::PIPE_DEPTH) rsp_last_out)
      else $error("last flag lost");

endmodule

`default_nettype wire

// File: hw/rtl/scmp_axis.sv
// one axis lane: scale by inverse pixel size, split into cell and fraction,
// form the pixel-center offset and wrap the cell into the map; uses scmp_pkg
`default_nettype none

module scmp_axis (
   input  wire logic                           clock,
   input  wire logic [scmp_pkg::MAG_W-1:0]     mag,
   input  wire logic                           neg,
   input  wire scmp_pkg::axis_cfg_type         cfg,
   output logic [scmp_pkg::SIDE_W-1:0]         cell_num,
   output logic signed [31:0]                  offset
);

   function automatic logic [scmp_pkg::SIDE_W-1:0] mod_group(
      input logic [scmp_pkg::SIDE_W-1:0]  r_start,
      input logic [scmp_pkg::GROUP_W-1:0] bits,
      input logic [scmp_pkg::SIDE_W-1:0]  side
   );
      logic [scmp_pkg::SIDE_W:0]   t;
      logic [scmp_pkg::SIDE_W-1:0] r;
      r = r_start;
      for (int i = scmp_pkg::GROUP_W - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= {1'b0, side}) begin
            t = t - {1'b0, side};
         end
         r = t[scmp_pkg::SIDE_W-1:0];
      end
      return r;
   endfunction

   // stage 1: partial products of magnitude and inverse pixel size
   logic [57:0] pp_lo_ff, pp_lo_in;
   logic [57:0] pp_hi_ff, pp_hi_in;
   // stage 2: full coordinate
   logic [83:0] sum_ff, sum_in;
   // stage 3: distance from pixel center
   logic [scmp_pkg::FRAC_W:0] dm_ff, dm_in;
   logic dneg_in;
   // stage 4: partial products of pixel size and distance
   logic [61:0] pp0_ff, pp0_in;
   logic [60:0] pp1_ff, pp1_in;
   // stage 5: full offset product
   logic [91:0] prod_ff, prod_in;
   // stage 6: rounded and saturated offset
   logic signed [31:0] off6_ff, off6_in;
   // stage 7: outputs
   logic [scmp_pkg::SIDE_W-1:0] cell_ff, cell_in;
   logic signed [31:0] off_ff;

   logic [1:6] neg_ff;
   logic [3:5] dneg_ff;
   logic [scmp_pkg::CELL_W-1:0] ipd_ff [0:scmp_pkg::GROUPS-2];
   logic [scmp_pkg::SIDE_W-1:0] rem_ff [0:scmp_pkg::GROUPS-1];
   logic [scmp_pkg::SIDE_W-1:0] rem_in [0:scmp_pkg::GROUPS-1];

   logic [scmp_pkg::FRAC_W-1:0] fr;
   logic [31:0] q;
   logic nz;
   logic signed [33:0] qs, o;

   always_comb begin
      pp_lo_in = 58'(mag[25:0]) * 58'(cfg.inverse_pixel_size);
      pp_hi_in = 58'(mag[scmp_pkg::MAG_W-1:26]) * 58'(cfg.inverse_pixel_size);

      sum_in = 84'(pp_lo_ff) + {pp_hi_ff, 26'b0};

      fr = sum_ff[scmp_pkg::FRAC_W-1:0];
      if (neg_ff[2]) begin
         dm_in = scmp_pkg::HALF_FRAC + {1'b0, fr};
         dneg_in = 1'b0;
      end else if (fr > scmp_pkg::HALF_FRAC_N) begin
         dm_in = {1'b0, fr} - scmp_pkg::HALF_FRAC;
         dneg_in = 1'b1;
      end else begin
         dm_in = scmp_pkg::HALF_FRAC - {1'b0, fr};
         dneg_in = 1'b0;
      end

      pp0_in = 62'(cfg.pixel_size) * 62'(dm_ff[30:0]);
      pp1_in = 61'(cfg.pixel_size) * 61'(dm_ff[scmp_pkg::FRAC_W:31]);

      prod_in = 92'(pp0_ff) + {pp1_ff, 31'b0};

      q = prod_ff[91:60];
      nz = |prod_ff[59:0];
      qs = $signed({2'b00, q});
      if (dneg_ff[5]) begin
         o = -qs - $signed({33'b0, nz});
      end else begin
         o = qs;
      end
      if (o > scmp_pkg::OFFSET_MAX) begin
         off6_in = 32'sh7FFF_FFFF;
      end else if (o < scmp_pkg::OFFSET_MIN) begin
         off6_in = 32'sh8000_0000;
      end else begin
         off6_in = o[31:0];
      end

      rem_in[0] = mod_group('0, sum_ff[83 -: scmp_pkg::GROUP_W], cfg.side);
      for (int k = 1; k < scmp_pkg::GROUPS; k++) begin
         rem_in[k] = mod_group(rem_ff[k-1],
            ipd_ff[k-1][scmp_pkg::CELL_W-1-scmp_pkg::GROUP_W*k -: scmp_pkg::GROUP_W],
            cfg.side);
      end

      if (neg_ff[6] && (rem_ff[scmp_pkg::GROUPS-1] != '0)) begin
         cell_in = cfg.side - rem_ff[scmp_pkg::GROUPS-1];
      end else begin
         cell_in = rem_ff[scmp_pkg::GROUPS-1];
      end
   end

   always_ff @(posedge clock) begin
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
      sum_ff <= sum_in;
      dm_ff <= dm_in;
      pp0_ff <= pp0_in;
      pp1_ff <= pp1_in;
      prod_ff <= prod_in;
      off6_ff <= off6_in;
      cell_ff <= cell_in;
      off_ff <= off6_ff;

      neg_ff[1] <= neg;
      for (int s = 2; s <= 6; s++) begin
         neg_ff[s] <= neg_ff[s-1];
      end
      dneg_ff[3] <= dneg_in;
      dneg_ff[4] <= dneg_ff[3];
      dneg_ff[5] <= dneg_ff[4];

      ipd_ff[0] <= sum_ff[83:scmp_pkg::FRAC_W];
      for (int k = 1; k < scmp_pkg::GROUPS - 1; k++) begin
         ipd_ff[k] <= ipd_ff[k-1];
      end
      for (int k = 0; k < scmp_pkg::GROUPS; k++) begin
         rem_ff[k] <= rem_in[k];
      end
   end

   assign cell_num = cell_ff;
   assign offset = off_ff;

endmodule

`default_nettype wire

// File: tb/pixel_map_checker.sv
// checker for sky_coord_to_map_pixel: follows csr writes, predicts the map pixel
// of every accepted sample and compares it with each result transaction
// depends on scmp_pkg for the csr register indexes
`timescale 1ns / 1ps

module pixel_map_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_right_ascension,
   input  logic signed [31:0] req_declination,
   input  logic signed [17:0] req_cos_declination,
   input  logic               req_last_in,
   input  logic               rsp_valid,
   input  logic [23:0]        rsp_pixel_index,
   input  logic signed [31:0] rsp_offset_x,
   input  logic signed [31:0] rsp_offset_y,
   input  logic               rsp_last_out,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 fail_count,
   output int                 outstanding
);

   localparam longint FRAC_HALF = 64'sh0800_0000_0000_0000;
   localparam longint OFFSET_TOP = 64'sd2147483647;
   localparam longint OFFSET_BOTTOM = -64'sd2147483648;
   localparam longint SIDE_CAP = 64'sd4096;

   typedef struct packed {
      logic [23:0] pixel_index;
      logic [31:0] offset_x;
      logic [31:0] offset_y;
      logic        last_out;
   } map_pixel_type;

   map_pixel_type expected_pixels[$];
   int mismatches = 0;

   longint      ra_scaled_min_q;
   longint      dec_min_q;
   longint      ra_centre_q;
   logic [30:0] pixel_size_q;
   logic [31:0] inv_pixel_q;
   logic [12:0] map_width_q;
   logic [12:0] map_height_q;

   task automatic load_defaults();
      ra_scaled_min_q = 0;
      dec_min_q = 0;
      ra_centre_q = 0;
      pixel_size_q = 31'd78090;
      inv_pixel_q = 32'd225296187;
      map_width_q = 13'd1024;
      map_height_q = 13'd1024;
   endtask

   // coordinate with 44 fraction bits -> truncated cell and Q4.28 offset from centre
   task automatic split_axis(input longint coord, output longint cell_num,
                             output logic [31:0] offset);
      logic [63:0]  mag;
      logic [127:0] prod;
      logic [63:0]  whole;
      logic [63:0]  frac;
      logic [63:0]  dm;
      logic [127:0] scaled;
      logic [63:0]  q;
      longint       f;
      longint       d;
      longint       o;
      bit           neg;
      bit           dneg;
      neg = coord < 0;
      mag = neg ? -coord : coord;
      prod = 128'(mag) * 128'(inv_pixel_q);
      whole = prod[123:60];
      frac = {4'd0, prod[59:0]};
      cell_num = neg ? -longint'(whole) : longint'(whole);
      f = neg ? -longint'(frac) : longint'(frac);
      d = FRAC_HALF - f;
      dneg = d < 0;
      dm = dneg ? -d : d;
      scaled = 128'(pixel_size_q) * 128'(dm);
      q = scaled[123:60];
      o = longint'(q);
      if (dneg) begin
         o = -o;
         if (scaled[59:0] != 60'd0)
            o = o - 1;
      end
      if (o > OFFSET_TOP)
         o = OFFSET_TOP;
      if (o < OFFSET_BOTTOM)
         o = OFFSET_BOTTOM;
      offset = o[31:0];
   endtask

   function automatic longint usable_side(input logic [12:0] side);
      if (side == 13'd0)
         return 1;
      if (longint'(side) > SIDE_CAP)
         return SIDE_CAP;
      return longint'(side);
   endfunction

   function automatic longint wrap_cell(input longint cell_num, input longint side);
      longint m;
      m = (cell_num < 0 ? -cell_num : cell_num) % side;
      if (cell_num < 0 && m != 0)
         m = side - m;
      return m;
   endfunction

   task automatic pixelize_sample(input logic signed [31:0] ra,
                                  input logic signed [31:0] dec,
                                  input logic signed [17:0] cos_dec,
                                  input logic last, output map_pixel_type pixel);
      longint      ux;
      longint      uy;
      longint      cell_x;
      longint      cell_y;
      longint      w;
      longint      h;
      longint      index;
      logic [31:0] off_x;
      logic [31:0] off_y;
      ux = (longint'(ra) - ra_centre_q) * longint'(cos_dec) - ra_scaled_min_q * 64'sd65536;
      uy = (longint'(dec) - dec_min_q) * 64'sd65536;
      split_axis(ux, cell_x, off_x);
      split_axis(uy, cell_y, off_y);
      w = usable_side(map_width_q);
      h = usable_side(map_height_q);
      index = wrap_cell(cell_x, w) + w * wrap_cell(cell_y, h);
      pixel.pixel_index = index[23:0];
      pixel.offset_x = off_x;
      pixel.offset_y = off_y;
      pixel.last_out = last;
   endtask

   task automatic apply_csr_write(input logic [2:0] index, input logic [31:0] data);
      case (index)
         scmp_pkg::CSR_RA_SCALED_MIN:      ra_scaled_min_q = longint'($signed(data));
         scmp_pkg::CSR_DEC_MIN:            dec_min_q = longint'($signed(data));
         scmp_pkg::CSR_RA_CENTRE:          ra_centre_q = longint'($signed(data));
         scmp_pkg::CSR_PIXEL_SIZE:         pixel_size_q = data[30:0];
         scmp_pkg::CSR_INVERSE_PIXEL_SIZE: inv_pixel_q = data;
         scmp_pkg::CSR_MAP_WIDTH:          map_width_q = data[12:0];
         scmp_pkg::CSR_MAP_HEIGHT:         map_height_q = data[12:0];
         default: ;
      endcase
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%h, actual 0x%h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      map_pixel_type want;
      map_pixel_type fresh;
      if (reset) begin
         load_defaults();
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready)
            apply_csr_write(csr_index, csr_wdata);
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               $error("result transaction with no sample in flight");
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("pixel_index", 32'(want.pixel_index), 32'(rsp_pixel_index));
               check_field("offset_x", want.offset_x, rsp_offset_x);
               check_field("offset_y", want.offset_y, rsp_offset_y);
               check_field("last_out", 32'(want.last_out), 32'(rsp_last_out));
            end
         end
         if (start && !busy) begin
            pixelize_sample(req_right_ascension, req_declination, req_cos_declination,
                            req_last_in, fresh);
            expected_pixels.push_back(fresh);
         end
      end
      fail_count <= mismatches;
      outstanding <= expected_pixels.size();
   end

endmodule

// File: tb/sky_coord_to_map_pixel_tb.sv
// testbench top for sky_coord_to_map_pixel: drives samples and csr writes
// through corner cases and random map settings; pixel_map_checker does the checking
// depends on scmp_pkg, sky_coord_to_map_pixel and pixel_map_checker
`timescale 1ns / 1ps

module sky_coord_to_map_pixel_tb;

   localparam int RANDOM_PHASES = 10;
   localparam int SAMPLES_PER_PHASE = 125;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] CSR_UNMAPPED = 3'd7;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_right_ascension;
   logic signed [31:0] req_declination;
   logic signed [17:0] req_cos_declination;
   logic               req_last_in;
   logic               rsp_valid;
   logic [23:0]        rsp_pixel_index;
   logic signed [31:0] rsp_offset_x;
   logic signed [31:0] rsp_offset_y;
   logic               rsp_last_out;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;
   int                 fail_count;
   int                 outstanding;
   int                 cycle_count = 0;

   // map settings last written, used to aim samples at the map
   logic signed [31:0] centre_set;
   logic signed [31:0] dec_min_set;

   always #5 clock = ~clock;

   sky_coord_to_map_pixel i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_right_ascension(req_right_ascension),
      .req_declination(req_declination),
      .req_cos_declination(req_cos_declination),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid),
      .rsp_pixel_index(rsp_pixel_index),
      .rsp_offset_x(rsp_offset_x),
      .rsp_offset_y(rsp_offset_y),
      .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pixel_map_checker i_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_right_ascension(req_right_ascension),
      .req_declination(req_declination),
      .req_cos_declination(req_cos_declination),
      .req_last_in(req_last_in),
      .rsp_valid(rsp_valid),
      .rsp_pixel_index(rsp_pixel_index),
      .rsp_offset_x(rsp_offset_x),
      .rsp_offset_y(rsp_offset_y),
      .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sky_coord_to_map_pixel test failed");
         $finish;
      end
   end

   // start stays high on return so back-to-back samples need no extra edge
   task automatic send_sample(input logic signed [31:0] ra, input logic signed [31:0] dec,
                              input logic signed [17:0] cos_dec, input logic last);
      @(negedge clock);
      start <= 1'b1;
      req_right_ascension <= ra;
      req_declination <= dec;
      req_cos_declination <= cos_dec;
      req_last_in <= last;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_gap(input bit steady);
      int gap;
      int pick;
      pick = $urandom_range(0, 9);
      if (steady || pick < 6)
         gap = 0;
      else if (pick < 9)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 40);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure_map(input logic [31:0] ra_min, input logic [31:0] dec_min,
                                input logic [31:0] centre, input logic [31:0] pix,
                                input logic [31:0] inv, input logic [31:0] width,
                                input logic [31:0] height);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(scmp_pkg::CSR_RA_SCALED_MIN, ra_min);
      write_register(scmp_pkg::CSR_DEC_MIN, dec_min);
      write_register(scmp_pkg::CSR_RA_CENTRE, centre);
      write_register(scmp_pkg::CSR_PIXEL_SIZE, pix);
      write_register(scmp_pkg::CSR_INVERSE_PIXEL_SIZE, inv);
      write_register(scmp_pkg::CSR_MAP_WIDTH, width);
      write_register(scmp_pkg::CSR_MAP_HEIGHT, height);
      @(negedge clock);
      csr_valid <= 1'b0;
      centre_set = centre;
      dec_min_set = dec_min;
   endtask

   // field extremes, cos beyond +-1, negative coordinates and the last flag
   task automatic corner_samples();
      send_sample(32'sd0, 32'sd0, 18'sd65536, 1'b0);
      send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 18'sd65536, 1'b0);
      send_sample(32'sh8000_0000, 32'sh8000_0000, -18'sd65536, 1'b1);
      send_sample(32'sh8000_0000, 32'sh7fff_ffff, 18'sh1ffff, 1'b0);
      send_sample(32'sh7fff_ffff, 32'sh8000_0000, 18'sh20000, 1'b1);
      send_sample(-32'sd1, -32'sd1, 18'sd1, 1'b0);
      send_sample(32'sd1000, -32'sd1000, 18'sd0, 1'b0);
   endtask

   task automatic random_map_settings();
      int          mode;
      int          pix;
      logic [63:0] inv;
      int          width;
      int          height;
      mode = $urandom_range(0, 3);
      if (mode < 2) begin
         // realistic map: consistent pixel size and inverse
         pix = $urandom_range(1000, 400000);
         inv = (64'd1 << 44) / pix + $urandom_range(0, 3);
         width = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4096);
         height = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 4096);
         configure_map(int'($urandom_range(0, 67108864)) - 33554432,
                       int'($urandom_range(0, 67108864)) - 33554432,
                       $urandom, pix, inv[31:0], width, height);
      end else if (mode == 2) begin
         configure_map($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(0, 8191), $urandom_range(0, 8191));
      end else begin
         configure_map($urandom, $urandom, $urandom, $urandom_range(1, 32'h7fff_ffff),
                       $urandom, $urandom_range(1, 8), $urandom_range(1, 8));
      end
   endtask

   task automatic random_sample();
      logic signed [31:0] ra;
      logic signed [31:0] dec;
      logic signed [17:0] cos_dec;
      logic [31:0]        cos_bits;
      if ($urandom_range(0, 9) < 7) begin
         ra = centre_set + (int'($urandom_range(0, 33554432)) - 16777216);
         dec = dec_min_set + int'($urandom_range(0, 16777216)) - 1024;
      end else begin
         ra = $urandom;
         dec = $urandom;
      end
      cos_bits = $urandom;
      if ($urandom_range(0, 9) == 0)
         cos_dec = cos_bits[17:0];
      else
         cos_dec = int'($urandom_range(0, 131072)) - 65536;
      send_sample(ra, dec, cos_dec, $urandom_range(0, 15) == 0);
   endtask

   initial begin
      bit steady;
      reset = 1'b1;
      start = 1'b0;
      req_right_ascension = '0;
      req_declination = '0;
      req_cos_declination = '0;
      req_last_in = 1'b0;
      csr_valid = 1'b0;
      csr_index = scmp_pkg::CSR_RA_SCALED_MIN;
      csr_wdata = '0;
      centre_set = '0;
      dec_min_set = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults after reset
      corner_samples();
      // widest pixel and inverse, side zero and side above the limit
      configure_map(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'hffff_ffff, 32'd0, 32'd8191);
      corner_samples();
      // zero pixel size and inverse, largest and smallest sides
      configure_map(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0,
                    32'd4096, 32'd1);
      write_register(CSR_UNMAPPED, $urandom);
      @(negedge clock);
      csr_valid <= 1'b0;
      corner_samples();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_map_settings();
         steady = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
            random_sample();
            if (n == SAMPLES_PER_PHASE / 2)
               drain();
            else
               idle_gap(steady);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("sky_coord_to_map_pixel test passed");
      else
         $display("sky_coord_to_map_pixel test failed");
      $finish;
   end

endmodule
